// ===== hw/rtl/ccac_pkg.sv =====
// Shared types, codes and constants for the call-cost aggregation cache.
`default_nettype none

package ccac_pkg;

   localparam int TABLE_DEPTH_DEFAULT = 16;

   localparam int ID_W    = 16;
   localparam int COST_W  = 48;
   localparam int COUNT_W = 32;

   localparam logic [1:0] MODE_CALL  = 2'd0;
   localparam logic [1:0] MODE_EXCL  = 2'd1;
   localparam logic [1:0] MODE_INIT  = 2'd2;
   localparam logic [1:0] MODE_FLUSH = 2'd3;

   typedef struct packed {
      logic [1:0]        mode;
      logic [ID_W-1:0]   caller_id;
      logic [ID_W-1:0]   callee_id;
      logic [ID_W-1:0]   level_tag;
      logic [COST_W-1:0] amount;
   } ccac_req_type;

   typedef struct packed {
      logic               is_exclusive;
      logic [ID_W-1:0]    out_caller;
      logic [ID_W-1:0]    out_callee;
      logic [ID_W-1:0]    out_level;
      logic [COUNT_W-1:0] call_count;
      logic [COST_W-1:0]  cost_sum;
      logic [COST_W-1:0]  total_cost;
      logic [COUNT_W-1:0] hit_total;
      logic [COUNT_W-1:0] miss_total;
      logic               final_item;
   } ccac_rsp_type;

   // Table key; exclusive entries carry a zero callee.
   typedef struct packed {
      logic            excl;
      logic [ID_W-1:0] caller;
      logic [ID_W-1:0] callee;
      logic [ID_W-1:0] level;
   } ccac_key_type;

endpackage

`default_nettype wire

// ===== hw/rtl/call_cost_aggregation_cache.sv =====
// Top level of the call-cost aggregation cache with round-robin eviction.
//
//   port group   dir   payload          handshake
//   req_*        in    ccac_req_type    req_valid / req_ready
//   rsp_*        out   ccac_rsp_type    rsp_valid / rsp_ready
//
// One item is handled at a time; req_ready is high only while the sequencer idles.
// A lookup walks the table through one memory read port and one key comparator,
// one entry per cycle. A hit adds an update state; an exclusive item first passes a
// subtract and an add state; an init item only loads its reading; a flush reads and
// emits each entry in turn. An eviction adds an emit state. A stalled rsp channel holds
// the sequencer in its emit state. Reset is synchronous; table contents are not cleared.
`default_nettype none

module call_cost_aggregation_cache
   import ccac_pkg::*;
#(
   parameter int TABLE_DEPTH = TABLE_DEPTH_DEFAULT
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   output logic              req_ready,
   input  wire ccac_req_type req_data,
   output logic              rsp_valid,
   input  wire logic         rsp_ready,
   output ccac_rsp_type      rsp_data
);

   localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
   localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(TABLE_DEPTH);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_EXCL_SUB,
      ST_EXCL_ADD,
      ST_LOOKUP,
      ST_HIT,
      ST_EVICT_EMIT,
      ST_FLUSH_READ,
      ST_FLUSH_EMIT
   } state_type;

   state_type          state_ff, state_in;
   logic [CNT_W-1:0]   ptr_ff, ptr_in;
   logic               chk_valid_ff, chk_valid_in;
   logic [IDX_W-1:0]   chk_idx_ff, chk_idx_in;
   logic [CNT_W-1:0]   fill_ff, fill_in;
   logic [IDX_W-1:0]   evict_ff, evict_in;
   logic [COST_W-1:0]  prev_ff, prev_in;
   logic [COST_W-1:0]  total_ff, total_in;
   logic [COUNT_W-1:0] hit_ff, hit_in;
   logic [COUNT_W-1:0] miss_ff, miss_in;
   ccac_key_type       key_ff, key_in;
   logic [COST_W-1:0]  cost_ff, cost_in;
   logic               rsp_valid_ff, rsp_valid_in;
   ccac_rsp_type       rsp_data_ff, rsp_data_in;

   ccac_key_type       key_mem_ff   [TABLE_DEPTH];
   logic [COUNT_W-1:0] calls_mem_ff [TABLE_DEPTH];
   logic [COST_W-1:0]  cost_mem_ff  [TABLE_DEPTH];
   ccac_key_type       rd_key_ff;
   logic [COUNT_W-1:0] rd_calls_ff;
   logic [COST_W-1:0]  rd_cost_ff;

   logic               mem_we;
   logic [IDX_W-1:0]   mem_wa;
   logic [COUNT_W-1:0] mem_wcalls;
   logic [COST_W-1:0]  mem_wcost;
   logic               mem_re;
   logic [IDX_W-1:0]   mem_ra;

   logic               hit_now;
   logic               rsp_free;
   logic               flush_last;
   ccac_rsp_type       rd_rsp;

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assign hit_now    = chk_valid_ff && (rd_key_ff == key_ff);
   assign rsp_free   = !rsp_valid_ff || rsp_ready;
   assign flush_last = (ptr_ff == fill_ff);

   always_comb begin
      rd_rsp.is_exclusive = rd_key_ff.excl;
      rd_rsp.out_caller   = rd_key_ff.caller;
      rd_rsp.out_callee   = rd_key_ff.callee;
      rd_rsp.out_level    = rd_key_ff.level;
      rd_rsp.call_count   = rd_calls_ff;
      rd_rsp.cost_sum     = rd_cost_ff;
      rd_rsp.total_cost   = total_ff;
      rd_rsp.hit_total    = hit_ff;
      rd_rsp.miss_total   = miss_ff;
      rd_rsp.final_item   = 1'b1;
   end

   always_comb begin
      state_in     = state_ff;
      ptr_in       = ptr_ff;
      chk_valid_in = chk_valid_ff;
      chk_idx_in   = chk_idx_ff;
      fill_in      = fill_ff;
      evict_in     = evict_ff;
      prev_in      = prev_ff;
      total_in     = total_ff;
      hit_in       = hit_ff;
      miss_in      = miss_ff;
      key_in       = key_ff;
      cost_in      = cost_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      mem_we       = 1'b0;
      mem_wa       = fill_ff[IDX_W-1:0];
      mem_wcalls   = COUNT_W'(1);
      mem_wcost    = cost_ff;
      mem_re       = 1'b0;
      mem_ra       = ptr_ff[IDX_W-1:0];

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               key_in.excl   = (req_data.mode == MODE_EXCL);
               key_in.caller = req_data.caller_id;
               key_in.callee = (req_data.mode == MODE_EXCL) ? '0 : req_data.callee_id;
               key_in.level  = req_data.level_tag;
               cost_in       = req_data.amount;
               ptr_in        = '0;
               chk_valid_in  = 1'b0;
               unique case (req_data.mode)
                  MODE_CALL: state_in = ST_LOOKUP;
                  MODE_EXCL: state_in = ST_EXCL_SUB;
                  MODE_INIT: prev_in  = req_data.amount;
                  MODE_FLUSH: begin
                     if (fill_ff != '0) begin
                        state_in = ST_FLUSH_READ;
                     end
                  end
                  default: state_in = ST_IDLE;
               endcase
            end
         end
         ST_EXCL_SUB: begin
            // cost_ff still holds the counter reading here.
            cost_in  = cost_ff - prev_ff;
            prev_in  = cost_ff;
            state_in = ST_EXCL_ADD;
         end
         ST_EXCL_ADD: begin
            total_in = total_ff + cost_ff;
            state_in = ST_LOOKUP;
         end
         ST_LOOKUP: begin
            if (hit_now) begin
               hit_in   = hit_ff + 1'b1;
               state_in = ST_HIT;
            end else if (ptr_ff < fill_ff) begin
               mem_re       = 1'b1;
               chk_valid_in = 1'b1;
               chk_idx_in   = ptr_ff[IDX_W-1:0];
               ptr_in       = ptr_ff + 1'b1;
            end else begin
               miss_in = miss_ff + 1'b1;
               if (fill_ff != DEPTH_CNT) begin
                  mem_we   = 1'b1;
                  fill_in  = fill_ff + 1'b1;
                  state_in = ST_IDLE;
               end else begin
                  // Table full: fetch the victim so it can be emitted first.
                  mem_re   = 1'b1;
                  mem_ra   = evict_ff;
                  state_in = ST_EVICT_EMIT;
               end
            end
         end
         ST_HIT: begin
            mem_we     = 1'b1;
            mem_wa     = chk_idx_ff;
            mem_wcalls = (rd_calls_ff == '1) ? rd_calls_ff : rd_calls_ff + 1'b1;
            mem_wcost  = rd_cost_ff + cost_ff;
            state_in   = ST_IDLE;
         end
         ST_EVICT_EMIT: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = rd_rsp;
               mem_we       = 1'b1;
               mem_wa       = evict_ff;
               evict_in     = (CNT_W'(evict_ff) + 1'b1 == DEPTH_CNT) ? '0 : evict_ff + 1'b1;
               state_in     = ST_IDLE;
            end
         end
         ST_FLUSH_READ: begin
            mem_re   = 1'b1;
            ptr_in   = ptr_ff + 1'b1;
            state_in = ST_FLUSH_EMIT;
         end
         ST_FLUSH_EMIT: begin
            if (rsp_free) begin
               rsp_valid_in           = 1'b1;
               rsp_data_in            = rd_rsp;
               rsp_data_in.final_item = flush_last;
               if (flush_last) begin
                  fill_in  = '0;
                  evict_in = '0;
                  state_in = ST_IDLE;
               end else begin
                  state_in = ST_FLUSH_READ;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         chk_valid_ff <= 1'b0;
         fill_ff      <= '0;
         evict_ff     <= '0;
         prev_ff      <= '0;
         total_ff     <= '0;
         hit_ff       <= '0;
         miss_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         chk_valid_ff <= chk_valid_in;
         fill_ff      <= fill_in;
         evict_ff     <= evict_in;
         prev_ff      <= prev_in;
         total_ff     <= total_in;
         hit_ff       <= hit_in;
         miss_ff      <= miss_in;
         rsp_valid_ff <= rsp_valid_in;
         ptr_ff       <= ptr_in;
         chk_idx_ff   <= chk_idx_in;
         key_ff       <= key_in;
         cost_ff      <= cost_in;
         rsp_data_ff  <= rsp_data_in;
      end
   end

   // Entry table: one write port and one registered read port.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         key_mem_ff[mem_wa]   <= key_ff;
         calls_mem_ff[mem_wa] <= mem_wcalls;
         cost_mem_ff[mem_wa]  <= mem_wcost;
      end
      if (mem_re) begin
         rd_key_ff   <= key_mem_ff[mem_ra];
         rd_calls_ff <= calls_mem_ff[mem_ra];
         rd_cost_ff  <= cost_mem_ff[mem_ra];
      end
   end

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= DEPTH_CNT)
      else $error("fill count exceeds table depth");

   a_emit_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == ST_EVICT_EMIT ||
                               $past(state_ff) == ST_FLUSH_EMIT))
      else $error("result loaded outside an emit state");

   a_evict_full: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_EVICT_EMIT |-> fill_ff == DEPTH_CNT)
      else $error("eviction while the table has free slots");

   a_flush_empties: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FLUSH_EMIT && rsp_free && flush_last) |=>
         (fill_ff == '0 && evict_ff == '0 && state_ff == ST_IDLE))
      else $error("flush did not empty the table");

endmodule

`default_nettype wire
